/* design/rse_pkg.sv */
// ----------------------------------------------------------------------------
// Record sort engine package
// Shared types, command codes and default sizes for the record sort engine.
// ----------------------------------------------------------------------------
package rse_pkg;

   localparam int RECORDS_DEF  = 8;
   localparam int NAME_LEN_DEF = 20;

   localparam logic [2:0] CMD_NAME_BYTE    = 3'd0;
   localparam logic [2:0] CMD_SURNAME_BYTE = 3'd1;
   localparam logic [2:0] CMD_NUMBERS      = 3'd2;
   localparam logic [2:0] CMD_SORT_SURNAME = 3'd3;
   localparam logic [2:0] CMD_SORT_NAME    = 3'd4;
   localparam logic [2:0] CMD_SORT_ID      = 3'd5;
   localparam logic [2:0] CMD_READ         = 3'd6;

   localparam logic KIND_SORT = 1'b0;
   localparam logic KIND_READ = 1'b1;

   typedef struct packed {
      logic [2:0]  command;
      logic [2:0]  slot;
      logic [4:0]  char_pos;
      logic [7:0]  char_value;
      logic [26:0] id_number;
      logic [7:0]  age_in;
      logic [4:0]  birth_day_in;
      logic [3:0]  birth_month_in;
      logic [13:0] birth_year_in;
      logic [4:0]  entry_day_in;
      logic [3:0]  entry_month_in;
      logic [13:0] entry_year_in;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  name_byte;
      logic [7:0]  surname_byte;
      logic [26:0] id_out;
      logic [7:0]  age_out;
      logic [4:0]  birth_day_out;
      logic [3:0]  birth_month_out;
      logic [13:0] birth_year_out;
      logic [4:0]  entry_day_out;
      logic [3:0]  entry_month_out;
      logic [13:0] entry_year_out;
   } rsp_type;

   // numeric part of one record as held in the record RAM
   typedef struct packed {
      logic [26:0] id;
      logic [7:0]  age;
      logic [4:0]  birth_day;
      logic [3:0]  birth_month;
      logic [13:0] birth_year;
      logic [4:0]  entry_day;
      logic [3:0]  entry_month;
      logic [13:0] entry_year;
   } nums_type;

endpackage

/* design/rse_ram.sv */
// ----------------------------------------------------------------------------
// Record sort engine RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/record_sort_engine_core.sv */
// ----------------------------------------------------------------------------
// Record sort engine core
// Record store with byte-serial name compare and three in-place sorts.
// ----------------------------------------------------------------------------
// Requests: a write takes effect at its accept edge, one per cycle while
//   idle; a read registers its slot and position, then the RAM data, then
//   the result; a sort ends with one result. Sorts make O(RECORDS^2) compares,
//   a name byte per pass or ids at once. req_stall is high during the
//   clearing pass and until a read or sort has its result registered.
// Reset: clears control, restores identity slot order, then clears the stores.
// ----------------------------------------------------------------------------
module record_sort_engine_core #(
   parameter int RECORDS  = rse_pkg::RECORDS_DEF,
   parameter int NAME_LEN = rse_pkg::NAME_LEN_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rse_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rse_pkg::rsp_type rsp_data
);

   localparam int IW    = $clog2(RECORDS);
   localparam int CW    = $clog2(RECORDS + 1);
   localparam int DEPTH = RECORDS * NAME_LEN;
   localparam int AW    = $clog2(DEPTH);
   localparam int KW    = $clog2(NAME_LEN);
   localparam int NW    = $bits(rse_pkg::nums_type);

   localparam logic [AW-1:0] NL_A = AW'(NAME_LEN);

   // sequencer states
   localparam logic [4:0] S_CLR       = 5'd0;
   localparam logic [4:0] S_IDLE      = 5'd1;
   localparam logic [4:0] S_RDA       = 5'd2;
   localparam logic [4:0] S_RDD       = 5'd3;
   localparam logic [4:0] S_INS_OUTER = 5'd4;
   localparam logic [4:0] S_INS_TEST  = 5'd5;
   localparam logic [4:0] S_INS_RES   = 5'd6;
   localparam logic [4:0] S_INS_PLACE = 5'd7;
   localparam logic [4:0] S_SEL_OUTER = 5'd8;
   localparam logic [4:0] S_SEL_TEST  = 5'd9;
   localparam logic [4:0] S_SEL_RES   = 5'd10;
   localparam logic [4:0] S_SEL_SWAP  = 5'd11;
   localparam logic [4:0] S_BUB_OUTER = 5'd12;
   localparam logic [4:0] S_BUB_TEST  = 5'd13;
   localparam logic [4:0] S_BUB_RES   = 5'd14;
   localparam logic [4:0] S_CA        = 5'd15;
   localparam logic [4:0] S_CD        = 5'd16;
   localparam logic [4:0] S_DONE      = 5'd17;

   // Records never move: perm maps a slot to its physical row, and the
   // sorts only permute this table.
   logic [IW-1:0] perm_ff [RECORDS];
   logic [IW-1:0] perm_in [RECORDS];

   logic [4:0]    state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] j_ff, j_in;
   logic [IW-1:0] m_ff, m_in;
   logic [IW-1:0] key_ff, key_in;
   logic [IW-1:0] cx_ff, cx_in;
   logic [IW-1:0] cy_ff, cy_in;
   logic [KW-1:0] k_ff, k_in;
   logic          lt_ff, lt_in;
   logic [2:0]    mode_ff, mode_in;
   logic [IW-1:0] rd_row_ff, rd_row_in;
   logic [KW-1:0] rd_pos_ff, rd_pos_in;
   logic          rd_slot_ok_ff, rd_slot_ok_in;
   logic          rd_pos_ok_ff, rd_pos_ok_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rse_pkg::rsp_type rsp_ff, rsp_in;

   logic          accept;
   logic          clearing;
   logic          sorting;
   logic          out_free;
   logic          slot_ok;
   logic          pos_ok;
   logic [IW-1:0] slot_row;
   logic [AW-1:0] wr_name_addr;

   logic [IW-1:0] a_row;
   logic [KW-1:0] a_pos;
   logic [AW-1:0] a_addr;
   logic [AW-1:0] b_addr;

   logic          first_we, sur_we, nums_we;
   logic [AW-1:0] name_waddr;
   logic [7:0]    name_wdata;
   logic [IW-1:0] nums_waddr;
   rse_pkg::nums_type nums_wdata;

   logic [7:0]    first_a, first_b, sur_a, sur_b;
   rse_pkg::nums_type nums_a, nums_b;

   logic [7:0]    byte_a, byte_b;

   assign accept   = req_valid && !req_stall;
   assign clearing = (state_ff == S_CLR);
   assign sorting  = !(state_ff == S_CLR || state_ff == S_IDLE ||
                       state_ff == S_RDA || state_ff == S_RDD);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // request decode
   assign slot_ok      = int'(req_data.slot) < RECORDS;
   assign pos_ok       = int'(req_data.char_pos) < NAME_LEN;
   assign slot_row     = perm_ff[IW'(req_data.slot)];
   assign wr_name_addr = AW'(slot_row) * NL_A + AW'(req_data.char_pos);

   // write side: clearing pass or a write request
   assign first_we = clearing || (accept && req_data.command == rse_pkg::CMD_NAME_BYTE &&
                                  slot_ok && pos_ok);
   assign sur_we   = clearing || (accept && req_data.command == rse_pkg::CMD_SURNAME_BYTE &&
                                  slot_ok && pos_ok);
   assign nums_we  = (clearing && int'(clr_ff) < RECORDS) ||
                     (accept && req_data.command == rse_pkg::CMD_NUMBERS && slot_ok);
   assign name_waddr = clearing ? clr_ff : wr_name_addr;
   assign name_wdata = clearing ? 8'd0 : req_data.char_value;
   assign nums_waddr = clearing ? IW'(clr_ff) : slot_row;

   always_comb begin
      if (clearing) begin
         nums_wdata = '0;
      end else begin
         nums_wdata.id          = req_data.id_number;
         nums_wdata.age         = req_data.age_in;
         nums_wdata.birth_day   = req_data.birth_day_in;
         nums_wdata.birth_month = req_data.birth_month_in;
         nums_wdata.birth_year  = req_data.birth_year_in;
         nums_wdata.entry_day   = req_data.entry_day_in;
         nums_wdata.entry_month = req_data.entry_month_in;
         nums_wdata.entry_year  = req_data.entry_year_in;
      end
   end

   // read side: port A serves reads and the left operand, port B the right
   assign a_row  = sorting ? cx_ff : rd_row_ff;
   assign a_pos  = sorting ? k_ff : rd_pos_ff;
   assign a_addr = AW'(a_row) * NL_A + AW'(a_pos);
   assign b_addr = AW'(cy_ff) * NL_A + AW'(k_ff);

   // each store is kept twice so two rows can be read in one cycle
   rse_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_first_a (
      .clock(clock), .wr_en(first_we), .wr_addr(name_waddr), .wr_data(name_wdata),
      .rd_addr(a_addr), .rd_data(first_a));
   rse_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_first_b (
      .clock(clock), .wr_en(first_we), .wr_addr(name_waddr), .wr_data(name_wdata),
      .rd_addr(b_addr), .rd_data(first_b));
   rse_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_sur_a (
      .clock(clock), .wr_en(sur_we), .wr_addr(name_waddr), .wr_data(name_wdata),
      .rd_addr(a_addr), .rd_data(sur_a));
   rse_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_sur_b (
      .clock(clock), .wr_en(sur_we), .wr_addr(name_waddr), .wr_data(name_wdata),
      .rd_addr(b_addr), .rd_data(sur_b));
   rse_ram #(.WIDTH(NW), .DEPTH(RECORDS)) u_nums_a (
      .clock(clock), .wr_en(nums_we), .wr_addr(nums_waddr), .wr_data(nums_wdata),
      .rd_addr(a_row), .rd_data(nums_a));
   rse_ram #(.WIDTH(NW), .DEPTH(RECORDS)) u_nums_b (
      .clock(clock), .wr_en(nums_we), .wr_addr(nums_waddr), .wr_data(nums_wdata),
      .rd_addr(cy_ff), .rd_data(nums_b));

   // name bytes under compare, chosen by sort key
   assign byte_a = (mode_ff == rse_pkg::CMD_SORT_SURNAME) ? sur_a : first_a;
   assign byte_b = (mode_ff == rse_pkg::CMD_SORT_SURNAME) ? sur_b : first_b;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      m_in          = m_ff;
      key_in        = key_ff;
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      k_in          = k_ff;
      lt_in         = lt_ff;
      mode_in       = mode_ff;
      rd_row_in     = rd_row_ff;
      rd_pos_in     = rd_pos_ff;
      rd_slot_ok_in = rd_slot_ok_ff;
      rd_pos_ok_in  = rd_pos_ok_ff;
      perm_in       = perm_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      case (state_ff)
         S_CLR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               case (req_data.command)
                  rse_pkg::CMD_READ: begin
                     rd_row_in     = slot_row;
                     rd_pos_in     = KW'(req_data.char_pos);
                     rd_slot_ok_in = slot_ok;
                     rd_pos_ok_in  = pos_ok;
                     state_in      = S_RDA;
                  end
                  rse_pkg::CMD_SORT_SURNAME: begin
                     mode_in  = req_data.command;
                     i_in     = CW'(1);
                     state_in = S_INS_OUTER;
                  end
                  rse_pkg::CMD_SORT_NAME: begin
                     mode_in  = req_data.command;
                     i_in     = '0;
                     state_in = S_SEL_OUTER;
                  end
                  rse_pkg::CMD_SORT_ID: begin
                     mode_in  = req_data.command;
                     i_in     = CW'(RECORDS - 1);
                     state_in = S_BUB_OUTER;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_RDA: begin
            state_in = S_RDD;
         end
         S_RDD: begin
            if (out_free) begin
               rsp_in      = '0;
               rsp_in.kind = rse_pkg::KIND_READ;
               if (rd_slot_ok_ff) begin
                  if (rd_pos_ok_ff) begin
                     rsp_in.name_byte    = first_a;
                     rsp_in.surname_byte = sur_a;
                  end
                  rsp_in.id_out          = nums_a.id;
                  rsp_in.age_out         = nums_a.age;
                  rsp_in.birth_day_out   = nums_a.birth_day;
                  rsp_in.birth_month_out = nums_a.birth_month;
                  rsp_in.birth_year_out  = nums_a.birth_year;
                  rsp_in.entry_day_out   = nums_a.entry_day;
                  rsp_in.entry_month_out = nums_a.entry_month;
                  rsp_in.entry_year_out  = nums_a.entry_year;
               end
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         // insertion sort by surname, j is the hole position
         S_INS_OUTER: begin
            if (i_ff == CW'(RECORDS)) begin
               state_in = S_DONE;
            end else begin
               key_in   = perm_ff[i_ff[IW-1:0]];
               j_in     = i_ff;
               state_in = S_INS_TEST;
            end
         end
         S_INS_TEST: begin
            if (j_ff == '0) begin
               state_in = S_INS_PLACE;
            end else begin
               cx_in    = key_ff;
               cy_in    = perm_ff[IW'(j_ff - 1'b1)];
               k_in     = '0;
               state_in = S_CA;
            end
         end
         S_INS_RES: begin
            if (lt_ff) begin
               perm_in[j_ff[IW-1:0]] = perm_ff[IW'(j_ff - 1'b1)];
               j_in     = j_ff - 1'b1;
               state_in = S_INS_TEST;
            end else begin
               state_in = S_INS_PLACE;
            end
         end
         S_INS_PLACE: begin
            perm_in[j_ff[IW-1:0]] = key_ff;
            i_in     = i_ff + 1'b1;
            state_in = S_INS_OUTER;
         end
         // selection sort by first name, first minimum wins
         S_SEL_OUTER: begin
            if (i_ff == CW'(RECORDS)) begin
               state_in = S_DONE;
            end else begin
               m_in     = i_ff[IW-1:0];
               j_in     = i_ff + 1'b1;
               state_in = S_SEL_TEST;
            end
         end
         S_SEL_TEST: begin
            if (j_ff == CW'(RECORDS)) begin
               state_in = S_SEL_SWAP;
            end else begin
               cx_in    = perm_ff[j_ff[IW-1:0]];
               cy_in    = perm_ff[m_ff];
               k_in     = '0;
               state_in = S_CA;
            end
         end
         S_SEL_RES: begin
            if (lt_ff) begin
               m_in = j_ff[IW-1:0];
            end
            j_in     = j_ff + 1'b1;
            state_in = S_SEL_TEST;
         end
         S_SEL_SWAP: begin
            perm_in[i_ff[IW-1:0]] = perm_ff[m_ff];
            perm_in[m_ff]         = perm_ff[i_ff[IW-1:0]];
            i_in     = i_ff + 1'b1;
            state_in = S_SEL_OUTER;
         end
         // bubble sort by id, i holds the pass limit
         S_BUB_OUTER: begin
            if (i_ff == '0) begin
               state_in = S_DONE;
            end else begin
               j_in     = '0;
               state_in = S_BUB_TEST;
            end
         end
         S_BUB_TEST: begin
            if (j_ff == i_ff) begin
               i_in     = i_ff - 1'b1;
               state_in = S_BUB_OUTER;
            end else begin
               cx_in    = perm_ff[IW'(j_ff + 1'b1)];
               cy_in    = perm_ff[j_ff[IW-1:0]];
               state_in = S_CA;
            end
         end
         S_BUB_RES: begin
            if (lt_ff) begin
               perm_in[j_ff[IW-1:0]]       = perm_ff[IW'(j_ff + 1'b1)];
               perm_in[IW'(j_ff + 1'b1)]   = perm_ff[j_ff[IW-1:0]];
            end
            j_in     = j_ff + 1'b1;
            state_in = S_BUB_TEST;
         end
         // compare row cx against row cy, one name byte per pass or the ids at once
         S_CA: begin
            state_in = S_CD;
         end
         S_CD: begin
            if (mode_ff == rse_pkg::CMD_SORT_ID) begin
               lt_in    = nums_a.id < nums_b.id;
               state_in = S_BUB_RES;
            end else if (byte_a != byte_b || byte_a == 8'd0 ||
                         k_ff == KW'(NAME_LEN - 1)) begin
               lt_in    = byte_a < byte_b;
               state_in = (mode_ff == rse_pkg::CMD_SORT_SURNAME) ? S_INS_RES : S_SEL_RES;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = S_CA;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_in       = '0;
               rsp_in.kind  = rse_pkg::KIND_SORT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int r = 0; r < RECORDS; r++) begin
            perm_ff[r] <= IW'(r);
         end
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         perm_ff      <= perm_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      i_ff          <= i_in;
      j_ff          <= j_in;
      m_ff          <= m_in;
      key_ff        <= key_in;
      cx_ff         <= cx_in;
      cy_ff         <= cy_in;
      k_ff          <= k_in;
      lt_ff         <= lt_in;
      mode_ff       <= mode_in;
      rd_row_ff     <= rd_row_in;
      rd_pos_ff     <= rd_pos_in;
      rd_slot_ok_ff <= rd_slot_ok_in;
      rd_pos_ok_ff  <= rd_pos_ok_in;
      rsp_ff        <= rsp_in;
   end

endmodule

/* design/rse_checker.sv */
// ----------------------------------------------------------------------------
// Record sort engine checker
// Port-level checks on the record sort engine, bound to the engine core.
// ----------------------------------------------------------------------------
module rse_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input rse_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input rse_pkg::rsp_type rsp_data
);

   // no result survives reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // a sort done result carries only its kind
   a_sort_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == rse_pkg::KIND_SORT |->
         rsp_data.name_byte == 8'd0 && rsp_data.surname_byte == 8'd0 &&
         rsp_data.id_out == 27'd0 && rsp_data.age_out == 8'd0 &&
         rsp_data.birth_day_out == 5'd0 && rsp_data.birth_month_out == 4'd0 &&
         rsp_data.birth_year_out == 14'd0 && rsp_data.entry_day_out == 5'd0 &&
         rsp_data.entry_month_out == 4'd0 && rsp_data.entry_year_out == 14'd0)
      else $error("sort result has data");

   // a read or sort request keeps the input closed on the next cycle
   a_busy_after_cmd: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall &&
      (req_data.command == rse_pkg::CMD_READ || req_data.command == rse_pkg::CMD_SORT_SURNAME ||
       req_data.command == rse_pkg::CMD_SORT_NAME || req_data.command == rse_pkg::CMD_SORT_ID)
      |=> req_stall)
      else $error("input open during command");

   // a write request never produces a result
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_valid &&
      (req_data.command == rse_pkg::CMD_NAME_BYTE ||
       req_data.command == rse_pkg::CMD_SURNAME_BYTE ||
       req_data.command == rse_pkg::CMD_NUMBERS) |=> !rsp_valid)
      else $error("result after write");

endmodule

bind record_sort_engine_core rse_checker u_rse_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .req_data(req_data),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data(rsp_data)
);

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record sort engine testbench
// Loads names and numeric fields into the record store, runs the three sorts
// and reads slots back. A scoreboard class keeps its own copy of the store,
// predicts every sort acknowledge and read, and checks the results in order.
// ----------------------------------------------------------------------------

class sort_scoreboard;
   localparam int NREC = rse_pkg::RECORDS_DEF;
   localparam int NLEN = rse_pkg::NAME_LEN_DEF;

   typedef struct {
      logic [7:0] first [NLEN];
      logic [7:0] last [NLEN];
      rse_pkg::nums_type nums;
   } person_type;

   person_type people [NREC];
   rse_pkg::rsp_type pending [$];
   int       mismatches;

   function void clear_store();
      foreach (people[i]) begin
         foreach (people[i].first[k]) begin
            people[i].first[k] = '0;
            people[i].last[k]  = '0;
         end
         people[i].nums = '0;
      end
   endfunction

   // strcmp-style compare over unsigned bytes, stops at the first NUL
   function int name_order(logic [7:0] a [NLEN], logic [7:0] b [NLEN]);
      for (int k = 0; k < NLEN; k++) begin
         if (a[k] != b[k]) return (a[k] < b[k]) ? -1 : 1;
         if (a[k] == 0) return 0;
      end
      return 0;
   endfunction

   function void order_by_surname();
      person_type key;
      int p;
      for (int i = 1; i < NREC; i++) begin
         key = people[i];
         p = i;
         while (p > 0 && name_order(key.last, people[p-1].last) < 0) begin
            people[p] = people[p-1];
            p--;
         end
         people[p] = key;
      end
   endfunction

   function void order_by_first_name();
      person_type t;
      int m;
      for (int i = 0; i < NREC; i++) begin
         m = i;
         for (int j = i + 1; j < NREC; j++)
            if (name_order(people[j].first, people[m].first) < 0) m = j;
         t = people[i];
         people[i] = people[m];
         people[m] = t;
      end
   endfunction

   function void order_by_id();
      person_type t;
      for (int i = 0; i < NREC - 1; i++)
         for (int j = 0; j < NREC - 1 - i; j++)
            if (people[j].nums.id > people[j+1].nums.id) begin
               t = people[j];
               people[j] = people[j+1];
               people[j+1] = t;
            end
   endfunction

   function void note_request(rse_pkg::req_type r);
      rse_pkg::rsp_type e;
      bit pos_ok;
      e = '0;
      pos_ok = r.char_pos < NLEN;
      case (r.command)
         rse_pkg::CMD_NAME_BYTE:
            if (pos_ok) people[r.slot].first[r.char_pos] = r.char_value;
         rse_pkg::CMD_SURNAME_BYTE:
            if (pos_ok) people[r.slot].last[r.char_pos] = r.char_value;
         rse_pkg::CMD_NUMBERS: begin
            people[r.slot].nums = {r.id_number, r.age_in, r.birth_day_in,
                                   r.birth_month_in, r.birth_year_in, r.entry_day_in,
                                   r.entry_month_in, r.entry_year_in};
         end
         rse_pkg::CMD_SORT_SURNAME, rse_pkg::CMD_SORT_NAME, rse_pkg::CMD_SORT_ID: begin
            if (r.command == rse_pkg::CMD_SORT_SURNAME) order_by_surname();
            else if (r.command == rse_pkg::CMD_SORT_NAME) order_by_first_name();
            else order_by_id();
            e.kind = rse_pkg::KIND_SORT;
            pending.push_back(e);
         end
         rse_pkg::CMD_READ: begin
            e.kind = rse_pkg::KIND_READ;
            if (pos_ok) begin
               e.name_byte    = people[r.slot].first[r.char_pos];
               e.surname_byte = people[r.slot].last[r.char_pos];
            end
            {e.id_out, e.age_out, e.birth_day_out, e.birth_month_out, e.birth_year_out,
             e.entry_day_out, e.entry_month_out, e.entry_year_out} = people[r.slot].nums;
            pending.push_back(e);
         end
         default: ;
      endcase
   endfunction

   function void check_result(rse_pkg::rsp_type got);
      rse_pkg::rsp_type e;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result %h", got);
         return;
      end
      e = pending.pop_front();
      if (got !== e) begin
         mismatches++;
         if (mismatches <= 10) $display("mismatch: expected %h, got %h", e, got);
      end
   endfunction
endclass

module tb_top;
   localparam int REQ_W = $bits(rse_pkg::req_type);

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   rse_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rse_pkg::rsp_type rsp_data;

   sort_scoreboard board = new();
   int  send_idle_pct = 0;   // percent of cycles the sender holds off
   int  recv_stall_pct = 0;  // percent of cycles the receiver stalls
   bit  hold_rsp = 1'b0;     // long receiver hold-off
   int  quiet_cycles = 0;

   always #1 clock = ~clock;

   record_sort_engine_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   // receiver side: stall is redrawn every falling edge
   always @(negedge clock) begin
      rsp_stall <= hold_rsp || ($urandom_range(99) < recv_stall_pct);
   end

   // result check and watchdog on the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) board.check_result(rsp_data);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles > 20000) begin
            $display("record_sort_engine_core test failed");
            $finish;
         end
      end
   end

   // offer one request, with random idle cycles ahead of it, and wait for accept;
   // valid stays high on return so the next request can follow with no gap
   task automatic send_request(rse_pkg::req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(r);
      @(negedge clock);
   endtask

   function automatic rse_pkg::req_type random_fill(logic [2:0] cmd);
      rse_pkg::req_type r;
      r = REQ_W'({$urandom, $urandom, $urandom, $urandom});
      r.command = cmd;
      return r;
   endfunction

   // mostly short names drawn from a small alphabet so that compares tie often
   task automatic load_name(logic [2:0] cmd, int slot);
      rse_pkg::req_type r;
      int len;
      len = $urandom_range(4);
      for (int k = 0; k <= len; k++) begin
         r = random_fill(cmd);
         r.slot = 3'(slot);
         r.char_pos = 5'(k);
         r.char_value = (k == len) ? 8'd0 :
                        ($urandom_range(9) == 0 ? 8'($urandom) : 8'(65 + $urandom_range(3)));
         send_request(r);
      end
   endtask

   task automatic random_request();
      rse_pkg::req_type r;
      int pick;
      pick = $urandom_range(99);
      if (pick < 30)      r = random_fill(rse_pkg::CMD_NAME_BYTE);
      else if (pick < 55) r = random_fill(rse_pkg::CMD_SURNAME_BYTE);
      else if (pick < 65) r = random_fill(rse_pkg::CMD_NUMBERS);
      else if (pick < 73) r = random_fill(3'($urandom_range(3, 5)));
      else if (pick < 97) r = random_fill(rse_pkg::CMD_READ);
      else                r = random_fill(3'd7);
      if (r.command == rse_pkg::CMD_NUMBERS && $urandom_range(1))
         r.id_number = 27'($urandom_range(7));   // repeated ids exercise stability
      if (r.command inside {rse_pkg::CMD_NAME_BYTE, rse_pkg::CMD_SURNAME_BYTE} &&
          $urandom_range(3) != 0) begin
         r.char_pos   = 5'($urandom_range(5));
         r.char_value = $urandom_range(1) ? 8'd0 : 8'(65 + $urandom_range(3));
      end
      send_request(r);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      rse_pkg::req_type r;
      board.clear_store();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, every command, unterminated names, bad positions
      r = random_fill(rse_pkg::CMD_NUMBERS); r.slot = 3'd7; r.id_number = '1; r.age_in = '1;
      r.birth_day_in = '1; r.birth_month_in = '1; r.birth_year_in = '1;
      r.entry_day_in = '1; r.entry_month_in = '1; r.entry_year_in = '1;
      send_request(r);
      r = '0; r.command = rse_pkg::CMD_NUMBERS; r.slot = 3'd0; send_request(r);
      r = random_fill(rse_pkg::CMD_NAME_BYTE); r.slot = 3'd3; r.char_pos = 5'd19;
      r.char_value = 8'hFF;
      send_request(r);
      r.char_pos = 5'd31; send_request(r);           // past the name, ignored
      r.command = rse_pkg::CMD_SURNAME_BYTE; r.char_pos = 5'd0; r.char_value = 8'hFF;
      send_request(r);
      for (int k = 0; k < 20; k++) begin             // unterminated surname in slot 5
         r = random_fill(rse_pkg::CMD_SURNAME_BYTE); r.slot = 3'd5; r.char_pos = 5'(k);
         r.char_value = 8'h5A;
         send_request(r);
      end
      r = random_fill(rse_pkg::CMD_READ); r.slot = 3'd7; r.char_pos = 5'd31; send_request(r);
      r = random_fill(rse_pkg::CMD_READ); r.slot = 3'd3; r.char_pos = 5'd19; send_request(r);
      r = random_fill(3'd7); send_request(r);
      r = random_fill(rse_pkg::CMD_SORT_SURNAME); send_request(r);
      r = random_fill(rse_pkg::CMD_SORT_NAME); send_request(r);
      r = random_fill(rse_pkg::CMD_SORT_ID); send_request(r);
      for (int s = 0; s < 8; s++) begin
         r = random_fill(rse_pkg::CMD_READ); r.slot = 3'(s); r.char_pos = 5'd0;
         send_request(r);
      end
      drain();

      // random phases: well-formed record loads, sorts and reads, plus noise
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
            3: begin send_idle_pct = 26; recv_stall_pct = 26; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         if (phase == 4) begin
            // long receiver hold-off while requests keep coming
            fork
               begin
                  hold_rsp = 1'b1;
                  repeat (300) @(posedge clock);
                  hold_rsp = 1'b0;
               end
            join_none
         end
         for (int n = 0; n < 6; n++) begin
            for (int s = 0; s < 8; s++) begin
               if ($urandom_range(1)) load_name(rse_pkg::CMD_NAME_BYTE, s);
               if ($urandom_range(1)) load_name(rse_pkg::CMD_SURNAME_BYTE, s);
               if ($urandom_range(2) == 0) begin
                  r = random_fill(rse_pkg::CMD_NUMBERS); r.slot = 3'(s);
                  if ($urandom_range(1)) r.id_number = 27'($urandom_range(5));
                  send_request(r);
               end
            end
            r = random_fill(3'($urandom_range(3, 5))); send_request(r);
            for (int s = 0; s < 8; s++) begin
               r = random_fill(rse_pkg::CMD_READ); r.slot = 3'(s);
               r.char_pos = 5'($urandom_range(4));
               send_request(r);
            end
            repeat (8) random_request();
         end
         drain();   // sender pauses until every result has arrived
      end

      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("record_sort_engine_core test passed");
      else
         $display("record_sort_engine_core test failed");
      $finish;
   end
endmodule
